// ===== rtl/npcs_pkg.sv =====
package npcs_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int COMP_W          = 8;
   localparam int INDEX_W         = 8;
   localparam int COLOR555_W      = 15;
   localparam int WORD_W          = 32;
   localparam int SQ_W            = 2 * COMP_W;
   localparam int DIST_W          = SQ_W + 2;

   localparam logic [COMP_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [COMP_W-1:0] ALPHA_CLEAR  = 8'h00;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   function automatic logic [COMP_W-1:0] widen5(input logic [4:0] c5);
      return {c5, 3'b100};
   endfunction

endpackage

// ===== rtl/npcs_cell.sv =====
module npcs_cell
   import npcs_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  rgb_type       load_data,
   input  rgb_type       shift_data,
   output rgb_type       entry
);

   rgb_type entry_ff;
   rgb_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = load_data;
      end else if (ctrl.shift) begin
         entry_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/npcs_dist.sv =====
module npcs_dist
   import npcs_pkg::*;
#(
   parameter int IDX_W = $clog2(PALETTE_ENTRIES)
)
(
   input  logic             clock,
   input  logic             reset,
   input  rgb_type          query,
   input  rgb_type          entry,
   input  logic             in_valid,
   input  logic             in_first,
   input  logic             in_last,
   input  logic [IDX_W-1:0] in_idx,
   output logic             done,
   output logic [IDX_W-1:0] best_idx
);

   function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                               input logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   logic             s1_valid_ff;
   logic             s1_first_ff;
   logic             s1_last_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [SQ_W-1:0]  sq_r_ff, sq_g_ff, sq_b_ff;

   logic [DIST_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]  bidx_ff, bidx_in;
   logic [DIST_W-1:0] distance;
   logic              take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= in_first;
      s1_last_ff  <= in_last;
      s1_idx_ff   <= in_idx;
      sq_r_ff     <= sq_diff(query.red,   entry.red);
      sq_g_ff     <= sq_diff(query.green, entry.green);
      sq_b_ff     <= sq_diff(query.blue,  entry.blue);
   end

   always_comb begin
      distance = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
      take     = s1_first_ff || (distance < best_ff);
      best_in  = best_ff;
      bidx_in  = bidx_ff;
      if (s1_valid_ff && take) begin
         best_in = distance;
         bidx_in = s1_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      bidx_ff <= bidx_in;
   end

   assign done     = s1_valid_ff && s1_last_ff;
   assign best_idx = bidx_in;

endmodule

// ===== rtl/nearest_palette_color_search_core.sv =====
// Channel   Ports                                     Handshake
// request   req_opcode, req_entry_index, req_red,     taken when start & !busy
//           req_green, req_blue, req_query_color
// response  rsp_packed_word, rsp_nearest_index        rsp_valid strobe, one cycle
//
// A load writes its palette cell at acceptance; its response comes the next cycle.
// A query rotates the ring of N palette cells past one distance unit, one entry per
// cycle, and responds after the distance stage; busy stays high until then.
// Reset is synchronous and clears control state only; palette cells hold no reset
// value and must all be loaded before a query. The receiver cannot stall responses.
module nearest_palette_color_search_core
   import npcs_pkg::*;
#(
   parameter int N = PALETTE_ENTRIES
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_opcode,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [COMP_W-1:0]     req_red,
   input  logic [COMP_W-1:0]     req_green,
   input  logic [COMP_W-1:0]     req_blue,
   input  logic [COLOR555_W-1:0] req_query_color,
   output logic                  rsp_valid,
   output logic [WORD_W-1:0]     rsp_packed_word,
   output logic [INDEX_W-1:0]    rsp_nearest_index
);

   localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   rgb_type          query_ff, query_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic accept, is_load, is_query, scanning, last;
   logic dist_done;
   logic [IDX_W-1:0] dist_idx;
   rgb_type          load_rgb;
   rgb_type          entries [N];
   cell_ctrl_type    cell_ctrl [N];

   assign accept   = start && !busy;
   assign is_load  = opcode_type'(req_opcode) == OP_LOAD;
   assign is_query = opcode_type'(req_opcode) == OP_QUERY;
   assign scanning = state_ff == ST_SCAN;
   assign last     = cnt_ff == IDX_W'(N - 1);
   assign load_rgb = '{blue: req_blue, green: req_green, red: req_red};

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         assign cell_ctrl[i].load  = accept && is_load && (req_entry_index == INDEX_W'(i));
         assign cell_ctrl[i].shift = scanning;

         npcs_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[i]),
            .load_data  (load_rgb),
            .shift_data (entries[(i + 1) % N]),
            .entry      (entries[i])
         );
      end
   endgenerate

   npcs_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .query    (query_ff),
      .entry    (entries[0]),
      .in_valid (scanning),
      .in_first (cnt_ff == '0),
      .in_last  (last),
      .in_idx   (cnt_ff),
      .done     (dist_done),
      .best_idx (dist_idx)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      query_in = query_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && is_query) begin
               state_in = ST_SCAN;
               query_in = '{blue:  widen5(req_query_color[14:10]),
                            green: widen5(req_query_color[9:5]),
                            red:   widen5(req_query_color[4:0])};
            end
         end
         ST_SCAN: begin
            if (last) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_word_in  = '0;
      rsp_idx_in   = '0;
      if (accept && is_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = {(req_entry_index == INDEX_W'(N - 1)) ? ALPHA_CLEAR : ALPHA_OPAQUE,
                         load_rgb};
      end else if (dist_done) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = INDEX_W'(dist_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   // pipeline tail keeps busy high until the best index is out
   assign busy              = scanning || dist_done;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packed_word   = rsp_word_ff;
   assign rsp_nearest_index = rsp_idx_ff;

   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      scanning |-> !rsp_valid_ff)
      else $error("response during palette scan");

   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && is_load) |=> rsp_valid_ff && (rsp_nearest_index == '0))
      else $error("load without response");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && is_query) |=> busy && scanning && (cnt_ff == '0))
      else $error("query did not start scan");

   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cnt_ff == '0))
      else $error("scan counter not parked");

endmodule

// ===== verif/nearest_palette_color_search_core_test.sv =====
module nearest_palette_color_search_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import npcs_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0]  packed_word;
      logic [INDEX_W-1:0] nearest_index;
   } palette_rsp_t;

   typedef struct packed {
      opcode_type             op;
      logic [INDEX_W-1:0]     entry;
      logic [COMP_W-1:0]      red;
      logic [COMP_W-1:0]      green;
      logic [COMP_W-1:0]      blue;
      logic [COLOR555_W-1:0]  color;
      logic                   known;
      logic [WORD_W-1:0]      word;
      logic [INDEX_W-1:0]     nearest;
   } directed_row_t;

   localparam int DIRECTED_ROWS = 18;
   localparam int PHASE_ITEMS   = 356;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_opcode = OP_LOAD;
   logic [INDEX_W-1:0]    req_entry_index = '0;
   logic [COMP_W-1:0]     req_red = '0;
   logic [COMP_W-1:0]     req_green = '0;
   logic [COMP_W-1:0]     req_blue = '0;
   logic [COLOR555_W-1:0] req_query_color = '0;
   logic                  rsp_valid;
   logic [WORD_W-1:0]     rsp_packed_word;
   logic [INDEX_W-1:0]    rsp_nearest_index;

   // typed-in expectation travelling with the item
   logic                  row_known = 1'b0;
   logic [WORD_W-1:0]     row_word = '0;
   logic [INDEX_W-1:0]    row_nearest = '0;

   rgb_type      palette_shadow [PALETTE_ENTRIES];
   palette_rsp_t pending_rsp [$];
   int           mismatch_count = 0;

   directed_row_t directed_rows [DIRECTED_ROWS] = '{
      '{OP_LOAD,  8'd0,   8'h04, 8'h04, 8'h04, 15'h5555, 1'b1, 32'hFF040404, 8'd0},
      '{OP_LOAD,  8'd4,   8'h00, 8'h00, 8'h00, 15'h2AAA, 1'b1, 32'hFF000000, 8'd0},
      '{OP_LOAD,  8'd255, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF, 1'b1, 32'h00FFFFFF, 8'd0},
      '{OP_LOAD,  8'd254, 8'hFF, 8'hFF, 8'hFF, 15'h0000, 1'b1, 32'hFFFFFFFF, 8'd0},
      '{OP_LOAD,  8'd1,   8'hFF, 8'h00, 8'h00, 15'h5555, 1'b1, 32'hFF0000FF, 8'd0},
      '{OP_LOAD,  8'd2,   8'h00, 8'hFF, 8'h00, 15'h5555, 1'b1, 32'hFF00FF00, 8'd0},
      '{OP_LOAD,  8'd3,   8'h00, 8'h00, 8'hFF, 15'h5555, 1'b1, 32'hFFFF0000, 8'd0},
      '{OP_LOAD,  8'd5,   8'h84, 8'h84, 8'h84, 15'h5555, 1'b1, 32'hFF848484, 8'd0},
      '{OP_LOAD,  8'd9,   8'h84, 8'h84, 8'h84, 15'h5555, 1'b1, 32'hFF848484, 8'd0},
      '{OP_QUERY, 8'hFF,  8'hFF, 8'hFF, 8'hFF, 15'h0000, 1'b1, 32'h0,        8'd0},
      '{OP_QUERY, 8'h00,  8'h00, 8'h00, 8'h00, 15'h4210, 1'b1, 32'h0,        8'd5},
      '{OP_QUERY, 8'hAA,  8'h55, 8'hAA, 8'h55, 15'h7FFF, 1'b0, 32'h0,        8'd0},
      '{OP_QUERY, 8'h55,  8'hAA, 8'h55, 8'hAA, 15'h001F, 1'b0, 32'h0,        8'd0},
      '{OP_QUERY, 8'h00,  8'h00, 8'h00, 8'h00, 15'h03E0, 1'b0, 32'h0,        8'd0},
      '{OP_QUERY, 8'h00,  8'h00, 8'h00, 8'h00, 15'h7C00, 1'b0, 32'h0,        8'd0},
      '{OP_LOAD,  8'd255, 8'h12, 8'h34, 8'h56, 15'h1234, 1'b1, 32'h00563412, 8'd0},
      '{OP_LOAD,  8'd128, 8'hAA, 8'h55, 8'hAA, 15'h4321, 1'b1, 32'hFFAA55AA, 8'd0},
      '{OP_QUERY, 8'h00,  8'h00, 8'h00, 8'h00, 15'h2A55, 1'b0, 32'h0,        8'd0}
   };

   nearest_palette_color_search_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_query_color   (req_query_color),
      .rsp_valid         (rsp_valid),
      .rsp_packed_word   (rsp_packed_word),
      .rsp_nearest_index (rsp_nearest_index)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // applies one item to the shadow palette and returns its response
   function automatic palette_rsp_t predict_palette_rsp(
      input logic                  op,
      input logic [INDEX_W-1:0]    entry,
      input logic [COMP_W-1:0]     red,
      input logic [COMP_W-1:0]     green,
      input logic [COMP_W-1:0]     blue,
      input logic [COLOR555_W-1:0] color
   );
      palette_rsp_t rsp;
      logic [COMP_W-1:0] alpha;
      int qr, qg, qb, dr, dg, db;
      int unsigned distance, best;
      rsp = '0;
      if (op == OP_LOAD) begin
         alpha = (int'(entry) == PALETTE_ENTRIES - 1) ? ALPHA_CLEAR : ALPHA_OPAQUE;
         if (int'(entry) < PALETTE_ENTRIES)
            palette_shadow[entry] = '{blue: blue, green: green, red: red};
         rsp.packed_word = {alpha, blue, green, red};
      end else begin
         qr = (int'(color[4:0]) << 3) + 4;
         qg = (int'(color[9:5]) << 3) + 4;
         qb = (int'(color[14:10]) << 3) + 4;
         best = 100_000_000;
         for (int e = 0; e < PALETTE_ENTRIES; e++) begin
            dr = qr - int'(palette_shadow[e].red);
            dg = qg - int'(palette_shadow[e].green);
            db = qb - int'(palette_shadow[e].blue);
            distance = dr * dr + dg * dg + db * db;
            if (distance < best) begin
               best = distance;
               rsp.nearest_index = e[INDEX_W-1:0];
            end
         end
      end
      return rsp;
   endfunction

   task automatic note_mismatch(input string what, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   // response check first, then the item accepted at this edge
   always @(posedge clock) begin
      palette_rsp_t want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               note_mismatch("unexpected response", '0, rsp_packed_word);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_packed_word !== want.packed_word)
                  note_mismatch("packed_word", want.packed_word, rsp_packed_word);
               if (rsp_nearest_index !== want.nearest_index)
                  note_mismatch("nearest_index", WORD_W'(want.nearest_index),
                                WORD_W'(rsp_nearest_index));
            end
         end
         if (start && !busy) begin
            want = predict_palette_rsp(req_opcode, req_entry_index, req_red, req_green,
                                       req_blue, req_query_color);
            if (row_known)
               want = '{packed_word: row_word, nearest_index: row_nearest};
            pending_rsp.push_back(want);
         end
      end
   end

   // called at a rising edge; returns at the edge that takes the item
   task automatic send_item(
      input opcode_type            op,
      input logic [INDEX_W-1:0]    entry,
      input logic [COMP_W-1:0]     red,
      input logic [COMP_W-1:0]     green,
      input logic [COMP_W-1:0]     blue,
      input logic [COLOR555_W-1:0] color,
      input logic                  known,
      input logic [WORD_W-1:0]     word,
      input logic [INDEX_W-1:0]    nearest,
      input int                    idle_pct
   );
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_opcode      <= op;
      req_entry_index <= entry;
      req_red         <= red;
      req_green       <= green;
      req_blue        <= blue;
      req_query_color <= color;
      row_known       <= known;
      row_word        <= word;
      row_nearest     <= nearest;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_for_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int idle_by_phase [4];
      opcode_type op;
      logic [INDEX_W-1:0] entry;
      logic [23:0] rgb;
      logic [COLOR555_W-1:0] color;
      rgb_type pick;
      int waited;

      idle_by_phase = '{0, 76, 19, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // every entry loaded before the first query
      for (int e = 0; e < PALETTE_ENTRIES; e++) begin
         rgb = 24'($urandom);
         send_item(OP_LOAD, e[INDEX_W-1:0], rgb[7:0], rgb[15:8], rgb[23:16],
                   COLOR555_W'($urandom), 1'b0, '0, '0, 0);
      end

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].entry, directed_rows[i].red,
                   directed_rows[i].green, directed_rows[i].blue, directed_rows[i].color,
                   directed_rows[i].known, directed_rows[i].word, directed_rows[i].nearest,
                   0);
      wait_for_responses();

      foreach (idle_by_phase[p]) begin
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            entry = INDEX_W'($urandom);
            rgb   = 24'($urandom);
            color = COLOR555_W'($urandom);
            if ($urandom_range(99) < 45) begin
               op = OP_LOAD;
               case ($urandom_range(9))
                  0: entry = INDEX_W'(PALETTE_ENTRIES - 1);
                  1: entry = '0;
                  default: ;
               endcase
               // duplicate colors make ties
               if ($urandom_range(4) == 0)
                  rgb = palette_shadow[$urandom_range(PALETTE_ENTRIES - 1)];
            end else begin
               op = OP_QUERY;
               if ($urandom_range(1) == 0) begin
                  pick  = palette_shadow[$urandom_range(PALETTE_ENTRIES - 1)];
                  color = {pick.blue[7:3], pick.green[7:3], pick.red[7:3]};
               end
            end
            send_item(op, entry, rgb[7:0], rgb[15:8], rgb[23:16], color, 1'b0, '0, '0,
                      idle_by_phase[p]);
         end
         wait_for_responses();
      end

      start <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 100_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (PALETTE_ENTRIES + 8) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0d responses never arrived", pending_rsp.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
